>>> hdl/kwsd_pkg.sv
// Shared types and constants for the keyword substitution decoder.
package kwsd_pkg;

  localparam int CHAR_W      = 8;
  localparam int FUNC_W      = 2;
  localparam int TABLE_DEPTH = 256;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [CHAR_W-1:0] SPACE_CHAR  = 8'd32;
  localparam logic [CHAR_W-1:0] PLAIN_START = 8'd97;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_KEY    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DECODE = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_KEY    = 2'd1,
    OP_DECODE = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
  } q_entry_t;

endpackage

>>> hdl/kwsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kwsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/kwsd_front.sv
// Front end: accept input transactions and classify them into queue operations.
module kwsd_front
  import kwsd_pkg::*;
(
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [CHAR_W-1:0] s_tdata,
  input  logic [FUNC_W-1:0] s_tuser,
  input  logic              q_full,
  output logic              push,
  output q_entry_t          entry
);

  logic keep;

  assign s_tready = !q_full;

  // Drop undefined functions and spaces in the key; they change nothing.
  always_comb begin
    entry.ch = s_tdata;
    entry.op = OP_CLEAR;
    keep     = 1'b0;
    unique case (s_tuser)
      FUNC_CLEAR: begin
        entry.op = OP_CLEAR;
        keep     = 1'b1;
      end
      FUNC_KEY: begin
        entry.op = OP_KEY;
        keep     = (s_tdata != SPACE_CHAR);
      end
      FUNC_DECODE: begin
        entry.op = OP_DECODE;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = s_tvalid && s_tready && keep;

endmodule

>>> hdl/kwsd_queue.sv
// Short register FIFO between the front end and the back end.
module kwsd_queue
  import kwsd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output logic     empty,
  output logic     full,
  output q_entry_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/kwsd_back.sv
// Back end: execute queued operations against the table and drive the result stage.
module kwsd_back
  import kwsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  q_entry_t          head,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [CHAR_W-1:0] m_tdata
);

  typedef enum logic [1:0] {
    KIND_ZERO   = 2'd0,
    KIND_SPACE  = 2'd1,
    KIND_MAPPED = 2'd2
  } kind_t;

  logic [TABLE_DEPTH-1:0] marks;
  logic [CHAR_W-1:0]      next_plain;
  logic                   r_valid;
  kind_t                  r_kind;
  logic [CHAR_W-1:0]      ram_q;
  logic                   can_out;
  logic                   do_key;
  logic                   do_clear;
  logic                   do_decode;
  logic                   key_new;

  assign can_out   = !r_valid || m_tready;
  assign pop       = !q_empty && ((head.op != OP_DECODE) || can_out);
  assign do_key    = pop && (head.op == OP_KEY);
  assign do_clear  = pop && (head.op == OP_CLEAR);
  assign do_decode = pop && (head.op == OP_DECODE);
  assign key_new   = do_key && !marks[head.ch];

  kwsd_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (key_new),
    .waddr (head.ch),
    .wdata (next_plain),
    .re    (do_decode),
    .raddr (head.ch),
    .rdata (ram_q)
  );

  // Marks and plain letter counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      marks      <= '0;
      next_plain <= PLAIN_START;
    end else if (do_clear) begin
      marks      <= '0;
      next_plain <= PLAIN_START;
    end else if (key_new) begin
      marks[head.ch] <= 1'b1;
      next_plain     <= next_plain + 1'b1;
    end
  end

  // Result stage; table data holds while stalled since reads fire only on load.
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (do_decode) begin
      r_valid <= 1'b1;
    end else if (m_tready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_decode) begin
      priority if (head.ch == SPACE_CHAR) begin
        r_kind <= KIND_SPACE;
      end else if (marks[head.ch]) begin
        r_kind <= KIND_MAPPED;
      end else begin
        r_kind <= KIND_ZERO;
      end
    end
  end

  always_comb begin
    unique case (r_kind)
      KIND_SPACE:  m_tdata = SPACE_CHAR;
      KIND_MAPPED: m_tdata = ram_q;
      default:     m_tdata = '0;
    endcase
  end

  assign m_tvalid = r_valid;

endmodule

>>> hdl/keyword_substitution_decoder_top.sv
// Keyword substitution decoder: front classifier, operation queue and table back end.
// A decode transaction accepted with the queue empty and the result stage free passes
//   through the queue slot, then the table read and result stage, to the master side;
//   clear and key transactions give no result.
// Throughput: one transaction per cycle while the queue has room and no stalled result holds
//   a decode; the back end does one table write per new key byte and one read per decode.
// Reset (rst, synchronous, active high): empties the queue and result stage,
//   clears all mapped marks and sets the next plain letter to 'a'; no clearing pass.
module keyword_substitution_decoder_top
  import kwsd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // Slave side: one operation per transaction.
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [CHAR_W-1:0] s_tdata,   // [7:0] char_in
  input  logic [FUNC_W-1:0] s_tuser,   // [1:0] func
  // Master side: one decoded byte per decode transaction.
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [CHAR_W-1:0] m_tdata    // [7:0] char_out
);

  logic     q_push;
  logic     q_pop;
  logic     q_empty;
  logic     q_full;
  q_entry_t q_in;
  q_entry_t q_head;

  // Front end: accept transactions while the queue has room, drop those that
  // change nothing (undefined function, space in the key).
  kwsd_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (q_push),
    .entry    (q_in)
  );

  // Queue: decouples input acceptance from result back-pressure.
  kwsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .empty      (q_empty),
    .full       (q_full),
    .head       (q_head)
  );

  // Back end: apply clear and key operations, look up decodes, hold results
  // in a registered output stage until the master side takes them.
  kwsd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head     (q_head),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

>>> hdl/kwsd_checker.sv
// Port-level checks for the keyword substitution decoder, bound to the top level.
module kwsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic [1:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // Hold a stalled result and its data.
  property p_out_hold;
    @(posedge clk) disable iff (rst)
      (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata));
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("stalled result changed");

  // Drop any result on reset.
  property p_reset_out;
    @(posedge clk) rst |=> !m_tvalid;
  endproperty
  a_reset_out: assert property (p_reset_out) else $error("result valid after reset");

  // Queue is empty after reset, so the input side is open.
  property p_reset_ready;
    @(posedge clk) rst |=> s_tready;
  endproperty
  a_reset_ready: assert property (p_reset_ready) else $error("not ready after reset");

  // With m_tvalid low now and at $past, and no reset at $past, the queue drains and input stays open.
  property p_no_stall_ready;
    @(posedge clk) disable iff (rst)
      (!m_tvalid && $past(!m_tvalid) && !$past(rst)) |-> s_tready;
  endproperty
  a_no_stall_ready: assert property (p_no_stall_ready)
    else $error("input stalled without output back-pressure");

endmodule

bind keyword_substitution_decoder_top kwsd_checker u_kwsd_checker (.*);
